// ===== design/ldc_pkg.sv =====
package ldc_pkg;

    // defaults for the top level parameters
    localparam int CODES_PER_LIST_DEF = 4;
    localparam int LEVEL_COUNT_DEF    = 8;

    localparam int CODE_W   = 32;
    localparam int ACTION_W = 3;
    localparam int CLICKS_W = 4;
    localparam int MODE_W   = 2;
    localparam int BRIGHT_W = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [CLICKS_W-1:0] HOLD_CLICKS_FOR_PROGRAM = 4'd3;

    // event kinds
    localparam logic [ACTION_W-1:0] ACT_CODE       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PLUS_CLICK = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MINUS_CLICK = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PLUS_HOLD  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MINUS_HOLD = 3'd4;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_LEARN_MINUS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEARN_PLUS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEARN_ON    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WORK        = 2'd3;

    // which list a code matched
    localparam logic [1:0] MATCH_NONE   = 2'd0;
    localparam logic [1:0] MATCH_PLUS   = 2'd1;
    localparam logic [1:0] MATCH_MINUS  = 2'd2;
    localparam logic [1:0] MATCH_TOGGLE = 2'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ldc_cmd_t;

    typedef struct packed {
        logic is_code;
        logic hit;
        logic last_slot;
        logic out_free;
    } ldc_sts_t;

endpackage

// ===== design/ldc_ctrl.sv =====
module ldc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ldc_pkg::ldc_sts_t sts,
    output ldc_pkg::ldc_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = sts.is_code ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.last_slot) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold the update until the result register can take it
                cmd.commit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ldc_dp.sv =====
module ldc_dp #(
    parameter int CODES_PER_LIST = ldc_pkg::CODES_PER_LIST_DEF,
    parameter int LEVEL_COUNT    = ldc_pkg::LEVEL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ldc_pkg::ldc_cmd_t             cmd,
    output ldc_pkg::ldc_sts_t             sts,
    input  logic [ldc_pkg::ACTION_W-1:0]  s_tuser,
    input  logic [ldc_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ldc_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int SLOT_W = (CODES_PER_LIST > 1) ? $clog2(CODES_PER_LIST) : 1;
    localparam int LVL_W  = (LEVEL_COUNT > 2) ? $clog2(LEVEL_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CODES_PER_LIST - 1);
    localparam logic [LVL_W-1:0]  LVL_MAX   = LVL_W'(LEVEL_COUNT - 1);

    logic [ldc_pkg::CODE_W-1:0]   plus_reg   [CODES_PER_LIST];
    logic [ldc_pkg::CODE_W-1:0]   minus_reg  [CODES_PER_LIST];
    logic [ldc_pkg::CODE_W-1:0]   toggle_reg [CODES_PER_LIST];

    logic [ldc_pkg::ACTION_W-1:0] action_reg;
    logic [ldc_pkg::CODE_W-1:0]   code_reg;
    logic [ldc_pkg::CLICKS_W-1:0] clicks_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [1:0]                   kind_reg;
    logic [1:0]                   kind_next;

    logic [LVL_W-1:0]             level_reg;
    logic [LVL_W-1:0]             level_next;
    logic [ldc_pkg::MODE_W-1:0]   mode_reg;
    logic [ldc_pkg::MODE_W-1:0]   mode_next;
    logic                         changed_reg;
    logic                         changed_next;

    logic                         m_tvalid_reg;
    logic [ldc_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic                         work;
    logic                         hit_plus;
    logic                         hit_minus;
    logic                         hit_toggle;
    logic                         long_hold;
    logic                         learn_en;
    logic                         learned;
    logic                         save;
    logic [LVL_W-1:0]             level_up;
    logic [LVL_W-1:0]             level_down;
    logic [LVL_W+2:0]             level_wide;

    assign work       = (mode_reg == ldc_pkg::MODE_WORK);
    assign hit_plus   = (plus_reg[slot_reg] == code_reg);
    assign hit_minus  = (minus_reg[slot_reg] == code_reg);
    assign hit_toggle = (toggle_reg[slot_reg] == code_reg);
    assign long_hold  = (clicks_reg >= ldc_pkg::HOLD_CLICKS_FOR_PROGRAM);
    assign level_up   = (level_reg == LVL_MAX) ? level_reg : level_reg + 1'b1;
    assign level_down = (level_reg == '0) ? level_reg : level_reg - 1'b1;

    // slot check: work mode looks at all three lists, learning only the current one
    always_comb begin
        kind_next = ldc_pkg::MATCH_NONE;
        if (work) begin
            priority if (hit_plus) begin
                kind_next = ldc_pkg::MATCH_PLUS;
            end else if (hit_minus) begin
                kind_next = ldc_pkg::MATCH_MINUS;
            end else if (hit_toggle) begin
                kind_next = ldc_pkg::MATCH_TOGGLE;
            end else begin
                kind_next = ldc_pkg::MATCH_NONE;
            end
        end else begin
            priority if (mode_reg == ldc_pkg::MODE_LEARN_MINUS) begin
                if (hit_minus) kind_next = ldc_pkg::MATCH_MINUS;
            end else if (mode_reg == ldc_pkg::MODE_LEARN_PLUS) begin
                if (hit_plus) kind_next = ldc_pkg::MATCH_PLUS;
            end else begin
                if (hit_toggle) kind_next = ldc_pkg::MATCH_TOGGLE;
            end
        end
    end

    assign sts.is_code   = (s_tuser == ldc_pkg::ACT_CODE);
    assign sts.hit       = (kind_next != ldc_pkg::MATCH_NONE);
    assign sts.last_slot = (slot_reg == LAST_SLOT);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // state update for the event
    always_comb begin
        level_next   = level_reg;
        mode_next    = mode_reg;
        changed_next = changed_reg;
        learn_en     = 1'b0;
        learned      = 1'b0;
        save         = 1'b0;
        if (work) begin
            unique case (action_reg)
                ldc_pkg::ACT_CODE: begin
                    unique case (kind_reg)
                        ldc_pkg::MATCH_PLUS:   level_next = level_up;
                        ldc_pkg::MATCH_MINUS:  level_next = level_down;
                        ldc_pkg::MATCH_TOGGLE: level_next = (level_reg != '0) ? '0 : LVL_MAX;
                        default:               level_next = level_reg;
                    endcase
                end
                ldc_pkg::ACT_PLUS_CLICK:  level_next = level_up;
                ldc_pkg::ACT_MINUS_CLICK: level_next = level_down;
                ldc_pkg::ACT_PLUS_HOLD:   level_next = LVL_MAX;
                ldc_pkg::ACT_MINUS_HOLD: begin
                    if (long_hold) begin
                        mode_next    = ldc_pkg::MODE_LEARN_MINUS;
                        changed_next = 1'b0;
                    end else begin
                        level_next = '0;
                    end
                end
                default: level_next = level_reg;
            endcase
        end else begin
            priority if (action_reg == ldc_pkg::ACT_CODE) begin
                learned = 1'b1;
                if (kind_reg == ldc_pkg::MATCH_NONE) begin
                    learn_en     = 1'b1;
                    changed_next = 1'b1;
                end
            end else if (action_reg == ldc_pkg::ACT_PLUS_CLICK) begin
                mode_next = (mode_reg == ldc_pkg::MODE_LEARN_ON) ?
                            ldc_pkg::MODE_LEARN_MINUS : mode_reg + 1'b1;
            end else if (action_reg == ldc_pkg::ACT_MINUS_HOLD && long_hold) begin
                save         = changed_reg;
                mode_next    = ldc_pkg::MODE_WORK;
                level_next   = LVL_MAX;
                changed_next = 1'b0;
            end else begin
                // other events are ignored while learning
                mode_next = mode_reg;
            end
        end
    end

    assign level_wide = {3'b000, level_next};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_tuser;
            code_reg   <= s_tdata[31:0];
            clicks_reg <= s_tdata[35:32];
            slot_reg   <= '0;
            kind_reg   <= ldc_pkg::MATCH_NONE;
        end else if (cmd.scan) begin
            kind_reg <= kind_next;
            if (slot_reg != LAST_SLOT) begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
        if (cmd.commit) begin
            m_tdata_reg <= {1'b0, save, learned, mode_next, level_wide[2:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CODES_PER_LIST; k++) begin
                plus_reg[k]   <= '0;
                minus_reg[k]  <= '0;
                toggle_reg[k] <= '0;
            end
            level_reg    <= '0;
            mode_reg     <= ldc_pkg::MODE_WORK;
            changed_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                level_reg    <= level_next;
                mode_reg     <= mode_next;
                changed_reg  <= changed_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // new code goes to the front, oldest entry drops off the end
            if (cmd.commit && learn_en) begin
                for (int k = 0; k < CODES_PER_LIST; k++) begin
                    if (mode_reg == ldc_pkg::MODE_LEARN_MINUS) begin
                        minus_reg[k] <= (k == 0) ? code_reg : minus_reg[(k > 0) ? k - 1 : 0];
                    end else if (mode_reg == ldc_pkg::MODE_LEARN_PLUS) begin
                        plus_reg[k] <= (k == 0) ? code_reg : plus_reg[(k > 0) ? k - 1 : 0];
                    end else begin
                        toggle_reg[k] <= (k == 0) ? code_reg : toggle_reg[(k > 0) ? k - 1 : 0];
                    end
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_MAX)
        else $error("level index above maximum");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed event gave no result");

    a_save_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[6] |-> m_tdata_reg[4:3] == ldc_pkg::MODE_WORK)
        else $error("save request outside work mode");

    a_learn_not_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && learn_en |-> !work && action_reg == ldc_pkg::ACT_CODE)
        else $error("list written outside learning");

endmodule

// ===== design/learned_remote_dimmer_control.sv =====
// Remote/button dimmer control. One event per request on the s_ side gives exactly one
// result on the m_ side. A button event (or an unused kind) goes straight to the commit
// state, which holds until the output register is free; a remote code first passes the
// scan state, where the learned code lists (all three in work mode) are compared one slot
// per cycle and the scan stops at the first match or at the last slot.
// The result sits in an output register, so the next event is accepted while an earlier
// result still waits for m_tready. Code lists reset to all zeros, so code 0 matches the
// slots still at zero (plus list first) until learned codes push them out.
module learned_remote_dimmer_control #(
    parameter int CODES_PER_LIST = ldc_pkg::CODES_PER_LIST_DEF,
    parameter int LEVEL_COUNT    = ldc_pkg::LEVEL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ldc_pkg::S_DATA_W-1:0]  s_tdata,  // ir_code[31:0], hold_clicks[35:32]
    input  logic [ldc_pkg::ACTION_W-1:0]  s_tuser,  // action[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // brightness_index[2:0], mode_now[4:3], learned[5], save_request[6]
    output logic [ldc_pkg::M_DATA_W-1:0]  m_tdata
);

    ldc_pkg::ldc_cmd_t cmd;
    ldc_pkg::ldc_sts_t sts;

    ldc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ldc_dp #(
        .CODES_PER_LIST (CODES_PER_LIST),
        .LEVEL_COUNT    (LEVEL_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
